FILE: sv/lcdw_pkg.sv
package lcdw_pkg;

  localparam int COL_MIN  = 0;
  localparam int COL_MAX  = 239;
  localparam int ROW_MIN  = 0;
  localparam int ROW_MAX  = 319;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 9;
  localparam int PIX_W  = 16;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 9;
  localparam int CNT_W  = 17;
  localparam int SPAN_W = 9;
  localparam int QUO_W  = 9;

  localparam int FULL_PIXELS = (COL_MAX - COL_MIN + 1) * (ROW_MAX - ROW_MIN + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET_COL  = 2'd0,
    FN_SET_PAGE = 2'd1,
    FN_WR_FIRST = 2'd2,
    FN_WR_NEXT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_DIV
  } bk_state_t;

  typedef struct packed {
    func_t             func;
    logic              sa_ok;
    logic              ea_ok;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [PIX_W-1:0]  pixel;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [COL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic [COL_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: sv/lcdw_if.sv
interface lcdw_in_if;
  import lcdw_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] end_addr;
  logic [PIX_W-1:0]  pixel;

  modport source (output valid, func, start_addr, end_addr, pixel, input ready);
  modport sink   (input valid, func, start_addr, end_addr, pixel, output ready);
endinterface

interface lcdw_out_if;
  import lcdw_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] color;

  modport source (output valid, col, row, color, input ready);
  modport sink   (input valid, col, row, color, output ready);
endinterface

FILE: sv/lcdw_front.sv
module lcdw_front (
  input  logic          clk,
  input  logic          rst_n,
  lcdw_in_if.sink       in_ch,
  output logic          cmd_valid,
  output lcdw_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import lcdw_pkg::*;

  logic vld_r;
  logic vld_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;
  logic is_page;
  logic [ADDR_W-1:0] lo_lim;
  logic [ADDR_W-1:0] hi_lim;

  assign in_ch.ready = !vld_r || cmd_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // limits depend only on which window edge is addressed
  assign is_page = (in_ch.func == FN_SET_PAGE);
  assign lo_lim  = is_page ? ADDR_W'(ROW_MIN) : ADDR_W'(COL_MIN);
  assign hi_lim  = is_page ? ADDR_W'(ROW_MAX) : ADDR_W'(COL_MAX);

  always_comb begin
    cmd_nxt.func       = func_t'(in_ch.func);
    cmd_nxt.start_addr = in_ch.start_addr;
    cmd_nxt.end_addr   = in_ch.end_addr;
    cmd_nxt.pixel      = in_ch.pixel;
    cmd_nxt.sa_ok      = (in_ch.start_addr >= lo_lim) && (in_ch.start_addr <= hi_lim);
    cmd_nxt.ea_ok      = (in_ch.end_addr >= lo_lim) && (in_ch.end_addr <= hi_lim);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (cmd_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

endmodule

FILE: sv/lcdw_fifo.sv
module lcdw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  lcdw_pkg::cmd_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output lcdw_pkg::cmd_t pop_data,
  input  logic           pop
);
  import lcdw_pkg::*;

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_CW-1:0] cnt_nxt;
  logic               push;

  assign push_ready = (cnt_r != FIFO_CW'(FIFO_DEPTH));
  assign push       = push_valid && push_ready;
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = FIFO_CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = FIFO_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/lcdw_div.sv
module lcdw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdw_pkg::div_req_t req,
  output lcdw_pkg::div_rsp_t rsp
);
  import lcdw_pkg::*;

  localparam int TRIAL_W = CNT_W + 1;
  localparam int STEP_W  = 4;

  logic               busy_r;
  logic               busy_nxt;
  logic               done_r;
  logic               done_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [STEP_W-1:0]  step_nxt;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   rem_nxt;
  logic [QUO_W-1:0]   quo_r;
  logic [QUO_W-1:0]   quo_nxt;
  logic [COL_W-1:0]   dvs_r;
  logic [COL_W-1:0]   dvs_nxt;
  logic [TRIAL_W-1:0] trial;

  // one quotient bit per cycle, most significant first
  assign trial = {1'b0, rem_r} - (TRIAL_W'(dvs_r) << step_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(QUO_W - 1);
      rem_nxt  = req.dividend;
      quo_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QUO_W-2:0], !trial[TRIAL_W-1]};
      if (!trial[TRIAL_W-1]) begin
        rem_nxt = trial[CNT_W-1:0];
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = STEP_W'(step_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[COL_W-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

FILE: sv/lcdw_back.sv
module lcdw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lcdw_pkg::cmd_t q_cmd,
  output logic           q_pop,
  lcdw_out_if.source     out_ch
);
  import lcdw_pkg::*;

  bk_state_t        state_r;
  bk_state_t        state_nxt;
  logic [COL_W-1:0] col_start_r;
  logic [COL_W-1:0] col_start_nxt;
  logic [COL_W-1:0] col_end_r;
  logic [COL_W-1:0] col_end_nxt;
  logic [ROW_W-1:0] page_start_r;
  logic [ROW_W-1:0] page_start_nxt;
  logic [ROW_W-1:0] page_end_r;
  logic [ROW_W-1:0] page_end_nxt;
  logic [CNT_W-1:0] pw_r;
  logic [CNT_W-1:0] pw_nxt;
  logic [CNT_W-1:0] wp_r;
  logic [CNT_W-1:0] wp_nxt;
  logic [COL_W-1:0] cur_col_r;
  logic [COL_W-1:0] cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r;
  logic [ROW_W-1:0] cur_row_nxt;

  logic             out_valid_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic [PIX_W-1:0] out_color_r;
  logic             load_out;
  logic             out_free;

  logic [COL_W-1:0]    new_cs;
  logic [ROW_W-1:0]    new_ps;
  logic                first;
  logic [CNT_W-1:0]    eff_pw;
  logic [COL_W-1:0]    eff_col;
  logic [ROW_W-1:0]    eff_row;
  logic                drop;
  logic [SPAN_W-1:0]   w_span;
  logic [SPAN_W-1:0]   h_span;
  logic [2*SPAN_W-1:0] prod;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  lcdw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  assign new_cs = q_cmd.sa_ok ? q_cmd.start_addr[COL_W-1:0] : col_start_r;
  assign new_ps = q_cmd.sa_ok ? q_cmd.start_addr : page_start_r;

  // a write-start item rewinds the count before it is placed
  assign first   = (q_cmd.func == FN_WR_FIRST);
  assign eff_pw  = first ? '0 : pw_r;
  assign eff_col = first ? col_start_r : cur_col_r;
  assign eff_row = first ? page_start_r : cur_row_r;
  assign drop    = (eff_pw >= wp_r);

  assign w_span = (col_end_r < col_start_r) ? '0 :
                  SPAN_W'({1'b0, col_end_r} - {1'b0, col_start_r} + 1'b1);
  assign h_span = (page_end_r < page_start_r) ? '0 :
                  SPAN_W'(page_end_r - page_start_r + 1'b1);
  assign prod   = w_span * h_span;

  always_comb begin
    state_nxt      = state_r;
    col_start_nxt  = col_start_r;
    col_end_nxt    = col_end_r;
    page_start_nxt = page_start_r;
    page_end_nxt   = page_end_r;
    pw_nxt         = pw_r;
    wp_nxt         = wp_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    q_pop          = 1'b0;
    load_out       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = pw_r;
    div_req.divisor  = w_span[COL_W-1:0];
    case (state_r)
      BK_RUN: begin
        if (q_valid) begin
          case (q_cmd.func)
            FN_SET_COL: begin
              q_pop         = 1'b1;
              col_start_nxt = new_cs;
              if (q_cmd.ea_ok && (q_cmd.end_addr >= {1'b0, new_cs})) begin
                col_end_nxt = q_cmd.end_addr[COL_W-1:0];
              end
              state_nxt = BK_MUL;
            end
            FN_SET_PAGE: begin
              q_pop          = 1'b1;
              page_start_nxt = new_ps;
              if (q_cmd.ea_ok && (q_cmd.end_addr >= new_ps)) begin
                page_end_nxt = q_cmd.end_addr;
              end
              state_nxt = BK_MUL;
            end
            default: begin
              if (drop || out_free) begin
                q_pop       = 1'b1;
                pw_nxt      = eff_pw;
                cur_col_nxt = eff_col;
                cur_row_nxt = eff_row;
                if (!drop) begin
                  load_out = 1'b1;
                  pw_nxt   = CNT_W'(eff_pw + 1'b1);
                  if (eff_col >= col_end_r) begin
                    cur_col_nxt = col_start_r;
                    cur_row_nxt = ROW_W'(eff_row + 1'b1);
                  end else begin
                    cur_col_nxt = COL_W'(eff_col + 1'b1);
                  end
                end
              end
            end
          endcase
        end
      end
      BK_MUL: begin
        wp_nxt = prod[CNT_W-1:0];
        if ((w_span == '0) || (h_span == '0)) begin
          cur_col_nxt = col_start_r;
          cur_row_nxt = page_start_r;
          state_nxt   = BK_RUN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = BK_DIV;
        end
      end
      BK_DIV: begin
        // realign cursors to count mod width, count div width
        if (div_rsp.done) begin
          cur_col_nxt = COL_W'(col_start_r + div_rsp.rem);
          cur_row_nxt = ROW_W'(page_start_r + div_rsp.quo);
          state_nxt   = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_RUN;
      col_start_r  <= COL_W'(COL_MIN);
      col_end_r    <= COL_W'(COL_MAX);
      page_start_r <= ROW_W'(ROW_MIN);
      page_end_r   <= ROW_W'(ROW_MAX);
      pw_r         <= '0;
      wp_r         <= CNT_W'(FULL_PIXELS);
      cur_col_r    <= COL_W'(COL_MIN);
      cur_row_r    <= ROW_W'(ROW_MIN);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_start_r  <= col_start_nxt;
      col_end_r    <= col_end_nxt;
      page_start_r <= page_start_nxt;
      page_end_r   <= page_end_nxt;
      pw_r         <= pw_nxt;
      wp_r         <= wp_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col_r   <= eff_col;
      out_row_r   <= eff_row;
      out_color_r <= q_cmd.pixel;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.col   = out_col_r;
  assign out_ch.row   = out_row_r;
  assign out_ch.color = out_color_r;

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == BK_DIV)
    else $error("divider result outside realign phase");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (eff_col >= col_start_r) && (eff_col <= col_end_r) &&
                 (eff_row >= page_start_r) && (eff_row <= page_end_r))
    else $error("pixel placed outside window");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= CNT_W'(FULL_PIXELS))
    else $error("window pixel count beyond panel");

endmodule

FILE: sv/lcd_window_write_address.sv
// channel   dir  transfer when     payload
// in_ch     in   valid & ready     func, start_addr, end_addr, pixel
// out_ch    out  valid & ready     col, row, color
//
// Pixel items stream at one per clock while the output is not stalled and no
// window item holds the executor; each passes the front register, the queue
// and the output register in that order.
// A set-column or set-page item holds the executor while it is issued, the
// window area is formed, the divider runs nine bit-serial steps and the
// realigned cursors are loaded; an empty new window skips the divider.
// The four-entry queue keeps taking items meanwhile.
// Synchronous active-low reset restores the full-panel window and zero count.
// A stalled output at once holds in the executor each pixel item that would be
// placed; the input stalls when the queue and the front register are full.
module lcd_window_write_address (
  input  logic        clk,
  input  logic        rst_n,
  lcdw_in_if.sink     in_ch,
  lcdw_out_if.source  out_ch
);
  import lcdw_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  lcdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  lcdw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_valid),
    .push_data  (cmd),
    .push_ready (cmd_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd),
    .pop        (q_pop)
  );

  lcdw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: verif/tb_lcd_window_write_address.sv
module tb_lcd_window_write_address;
  import lcdw_pkg::*;

  localparam int LIMIT = 400000;
  localparam int PHASE_ITEMS = 300;
  localparam int MAX_PRINT = 40;

  typedef enum logic [1:0] {
    BY_MODEL,
    GIVEN_PIXEL,
    GIVEN_NONE
  } exp_src_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] color;
  } pix_t;

  typedef struct packed {
    func_t             f;
    logic [ADDR_W-1:0] sa;
    logic [ADDR_W-1:0] ea;
    logic [PIX_W-1:0]  px;
    exp_src_t          src;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
  } step_t;

  logic clk;
  logic rst_n = 1'b0;

  lcdw_in_if  in_ch ();
  lcdw_out_if out_ch ();

  lcd_window_write_address dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // window tracker state
  logic [COL_W-1:0] win_col_lo, win_col_hi;
  logic [ROW_W-1:0] win_page_lo, win_page_hi;
  int unsigned      n_drawn, win_area, cur_x, cur_y;

  pix_t pending_pixels[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   item_count = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;

  step_t script [25];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_pixels.size());
      $display("** lcd_window_write_address: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINT)
      $display("mismatch %s: got %0d expected %0d (result %0d, cycle %0d)",
               what, got, want, results_seen, cycles);
  endtask

  function automatic void realign_cursor();
    int unsigned w, h;
    w = (win_col_hi < win_col_lo) ? 0 : win_col_hi - win_col_lo + 1;
    h = (win_page_hi < win_page_lo) ? 0 : win_page_hi - win_page_lo + 1;
    if (w == 0 || h == 0) begin
      win_area = 0;
      cur_x = win_col_lo;
      cur_y = win_page_lo;
    end else begin
      win_area = w * h;
      cur_x = win_col_lo + n_drawn % w;
      cur_y = win_page_lo + n_drawn / w;
    end
  endfunction

  function automatic void reset_window();
    win_col_lo = COL_MIN;
    win_col_hi = COL_MAX;
    win_page_lo = ROW_MIN;
    win_page_hi = ROW_MAX;
    n_drawn = 0;
    realign_cursor();
  endfunction

  // Returns 1 when the item places a pixel; r then holds its position.
  function automatic bit map_pixel(input func_t f, input logic [ADDR_W-1:0] sa,
                                   input logic [ADDR_W-1:0] ea,
                                   input logic [PIX_W-1:0] px, output pix_t r);
    r = '0;
    case (f)
      FN_SET_COL: begin
        if (sa >= COL_MIN && sa <= COL_MAX) win_col_lo = COL_W'(sa);
        if (ea >= win_col_lo && ea >= COL_MIN && ea <= COL_MAX) win_col_hi = COL_W'(ea);
        realign_cursor();
        return 1'b0;
      end
      FN_SET_PAGE: begin
        if (sa >= ROW_MIN && sa <= ROW_MAX) win_page_lo = ROW_W'(sa);
        if (ea >= win_page_lo && ea >= ROW_MIN && ea <= ROW_MAX) win_page_hi = ROW_W'(ea);
        realign_cursor();
        return 1'b0;
      end
      FN_WR_FIRST: begin
        n_drawn = 0;
        cur_x = win_col_lo;
        cur_y = win_page_lo;
      end
      default: ;
    endcase
    if (n_drawn >= win_area) return 1'b0;
    r.col = COL_W'(cur_x);
    r.row = ROW_W'(cur_y);
    r.color = px;
    n_drawn++;
    if (cur_x >= win_col_hi) begin
      cur_x = win_col_lo;
      cur_y++;
    end else begin
      cur_x++;
    end
    return 1'b1;
  endfunction

  task automatic drive_item(input func_t f, input logic [ADDR_W-1:0] sa,
                            input logic [ADDR_W-1:0] ea, input logic [PIX_W-1:0] px,
                            input exp_src_t src, input pix_t given);
    int gap;
    bit hit;
    pix_t r;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.start_addr <= sa;
    in_ch.end_addr   <= ea;
    in_ch.pixel      <= px;
    do @(posedge clk); while (!in_ch.ready);
    // transfer taken at this edge
    hit = map_pixel(f, sa, ea, px, r);
    case (src)
      BY_MODEL:    if (hit) pending_pixels.push_back(r);
      GIVEN_PIXEL: pending_pixels.push_back(given);
      default: ;
    endcase
    if (hit || f == FN_SET_COL || f == FN_SET_PAGE) item_count++;
  endtask

  task automatic drive_random(input func_t f, input logic [ADDR_W-1:0] sa,
                              input logic [ADDR_W-1:0] ea);
    drive_item(f, sa, ea, PIX_W'($urandom), BY_MODEL, '0);
  endtask

  task automatic drive_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      drive_random(func_t'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 511)),
                   ADDR_W'($urandom_range(0, 511)));
  endtask

  // Set a window, then fill it from the first pixel to a little past its end.
  task automatic fill_window();
    int pick, cs, ce, ps, pe, n;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      cs = COL_MIN;
      ce = COL_MAX;
      ps = $urandom_range(ROW_MIN, ROW_MAX);
      pe = ps;
    end else if (pick == 1) begin
      cs = COL_MAX - $urandom_range(0, 3);
      ce = COL_MAX;
      ps = ROW_MAX - $urandom_range(0, 3);
      pe = ROW_MAX;
    end else begin
      cs = $urandom_range(COL_MIN, COL_MAX);
      ce = cs + $urandom_range(0, 7);
      ps = $urandom_range(ROW_MIN, ROW_MAX);
      pe = ps + $urandom_range(0, 5);
    end
    drive_random(FN_SET_COL, ADDR_W'(cs), ADDR_W'(ce));
    drive_random(FN_SET_PAGE, ADDR_W'(ps), ADDR_W'(pe));
    n = win_area + $urandom_range(0, 3);
    if (n > 300) n = 300;
    drive_random(FN_WR_FIRST, ADDR_W'($urandom), ADDR_W'($urandom));
    for (int i = 1; i < n; i++) begin
      // occasional window move in the middle of a write
      if ($urandom_range(0, 39) == 0) begin
        cs = $urandom_range(COL_MIN, COL_MAX);
        ps = $urandom_range(ROW_MIN, ROW_MAX);
        drive_random(func_t'($urandom_range(0, 1)), ADDR_W'(cs),
                     ADDR_W'(cs + $urandom_range(0, 9)));
      end
      drive_random(FN_WR_NEXT, ADDR_W'($urandom), ADDR_W'($urandom));
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    pix_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.col, out_ch.row, out_ch.color};
      results_seen++;
      if (pending_pixels.size() == 0) begin
        report("unexpected result col", got.col, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.col !== want.col) report("col", got.col, want.col);
        if (got.row !== want.row) report("row", got.row, want.row);
        if (got.color !== want.color) report("color", got.color, want.color);
      end
    end
  end

  initial begin
    int target;
    pix_t given;
    in_ch.valid = 1'b0;
    in_ch.func = FN_SET_COL;
    in_ch.start_addr = '0;
    in_ch.end_addr = '0;
    in_ch.pixel = '0;
    reset_window();

    script = '{
      '{FN_WR_FIRST, 9'd0,   9'd0,   16'hFFFF, GIVEN_PIXEL, 8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h0000, GIVEN_PIXEL, 8'd1,   9'd0},
      '{FN_SET_COL,  9'd511, 9'd511, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_SET_PAGE, 9'd320, 9'd511, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'hA5A5, GIVEN_PIXEL, 8'd2,   9'd0},
      '{FN_SET_COL,  9'd239, 9'd239, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h1234, GIVEN_PIXEL, 8'd239, 9'd3},
      '{FN_SET_PAGE, 9'd319, 9'd319, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h5A5A, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_FIRST, 9'd0,   9'd0,   16'h5A5A, GIVEN_PIXEL, 8'd239, 9'd319},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h0F0F, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_SET_COL,  9'd10,  9'd20,  16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      // start moves past the old end: empty window
      '{FN_SET_COL,  9'd30,  9'd511, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_FIRST, 9'd0,   9'd0,   16'h8001, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h8002, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_SET_COL,  9'd0,   9'd511, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_SET_PAGE, 9'd0,   9'd1,   16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_SET_COL,  9'd5,   9'd6,   16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_FIRST, 9'd0,   9'd0,   16'h7FFF, BY_MODEL,    8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'hFFFE, BY_MODEL,    8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h0001, BY_MODEL,    8'd0,   9'd0},
      // width change mid-write realigns the cursor
      '{FN_SET_COL,  9'd0,   9'd2,   16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'hC3C3, BY_MODEL,    8'd0,   9'd0},
      '{FN_SET_PAGE, 9'd300, 9'd100, 16'h0000, GIVEN_NONE,  8'd0,   9'd0},
      '{FN_WR_NEXT,  9'd0,   9'd0,   16'h3C3C, GIVEN_NONE,  8'd0,   9'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      given = '{script[i].x, script[i].y, script[i].px};
      drive_item(script[i].f, script[i].sa, script[i].ea, script[i].px,
                 script[i].src, given);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      // long output hold-off while the sender keeps offering items
      if (phase == 0 || phase == 2) hold_left = 150;
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        if ($urandom_range(99) < 15) drive_noise();
        else fill_window();
      end
      // sender pauses until the block has drained
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (pending_pixels.size() != 0);
    end

    repeat (20) @(posedge clk);
    $display("ran %0d window/pixel items in %0d cycles, %0d pixel results checked",
             item_count, cycles, results_seen);
    $display("pacing: free-running, sparse input, heavy output stall, mixed; two hold-offs");
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("** lcd_window_write_address: PASSED **");
    else
      $display("** lcd_window_write_address: FAILED **");
    $finish;
  end

endmodule
